/* hdl/smba_pkg.sv */
// Shared types and constants for the shard memory budget accountant.
`default_nettype none

package smba_pkg;

   localparam int CTR_W = 56;
   localparam int AMT_W = 48;
   localparam int CAP_W = 33;
   localparam int LIM_W = 34;

   localparam logic [63:0] MIN_CAP = 64'd67108864;
   localparam logic [63:0] MAX_CAP = 64'd4294967296;

   localparam logic [CTR_W-1:0] CTR_MAX = {1'b0, {(CTR_W-1){1'b1}}};
   localparam logic [CTR_W-1:0] CTR_MIN = {1'b1, {(CTR_W-1){1'b0}}};

   localparam logic [6:0] SHARD_NONE = 7'h7F;

   typedef enum logic [1:0] {
      OP_CHECK   = 2'd0,
      OP_SOFT    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_STATUS  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   // cap plus slack is the checked-reserve limit
   typedef struct packed {
      logic [LIM_W-1:0] limit;
      logic [CAP_W-1:0] cap;
   } budget_type;

endpackage

`default_nettype wire

/* hdl/sharded_memory_budget_accountant.sv */
// Top level of the sharded memory budget accountant.
//  - req_ channel: one transfer is one operation (checked reserve, soft
//    reserve, release or status read) with amount, requested shard and home
//    shard. rsp_ channel: one transfer per request with grant, charged shard,
//    total, headroom, cap and peak.
//  - csr_ port: register 0 (page buffer pages) at 0x0, register 1 (work
//    memory limit) at 0x8; decode uses paddr bit 3. pready is tied high.
//  - Each request passes through accept (counter read issued to the
//    shard RAM), execute (saturating add on the read data) and commit
//    (limit check, RAM write-back, response register load). A new request is
//    accepted only once the previous one has committed; that is set by the counter
//    read-modify-write through the single-port-read shard RAM.
//  - One request is in flight at a time, so a counter is never read while
//    its write-back is pending; no forwarding path is needed.
//  - A request may be accepted while the previous response still waits; the
//    commit step holds until the response register is free.
//  - After a csr write, requests are held off while the cap pipeline
//    settles, and also while a csr transfer is in progress.
//  - Reset clears totals, per-shard valid bits (unwritten shards read as
//    zero, no clearing pass) and the configuration; cap resets to 64 MiB.
`default_nettype none

module sharded_memory_budget_accountant
   import smba_pkg::*;
#(
   parameter int SHARDS         = 64,
   parameter int PAGE_BYTES     = 16384,
   parameter int REFILL_QUANTUM = 262144
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: tdata = amount[47:0], shard_req[54:48], home_shard[60:55]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,
   // request: tuser = op[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // response: tdata = granted[0], shard_used[7:1], total[69:8],
   // headroom[102:70], cap_now[135:103], peak_reserved[197:136]
   output logic [199:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int         IDX_W   = (SHARDS > 1) ? $clog2(SHARDS) : 1;
   localparam int         POS_W   = CTR_W - 1;
   localparam int         TOT_W   = $clog2(SHARDS) + POS_W;
   localparam logic [8:0] SHARDS9 = 9'(SHARDS);

   // ---------------- configuration registers ----------------
   logic        csr_wr;
   logic [30:0] pages_ff, pages_in;
   logic [47:0] wml_ff, wml_in;
   logic [1:0]  settle_ff, settle_in;
   budget_type  budget;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_paddr[3] ? 64'(wml_ff) : 64'(pages_ff);

   always_comb begin
      pages_in = pages_ff;
      wml_in   = wml_ff;
      if (csr_wr) begin
         if (csr_paddr[3]) begin
            wml_in = csr_pwdata[47:0];
         end else begin
            pages_in = csr_pwdata[30:0];
         end
      end
      if (csr_wr) begin
         settle_in = 2'd3;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff  <= '0;
         wml_ff    <= '0;
         settle_ff <= '0;
      end else begin
         pages_ff  <= pages_in;
         wml_ff    <= wml_in;
         settle_ff <= settle_in;
      end
   end

   smba_cap #(
      .SHARDS         (SHARDS),
      .PAGE_BYTES     (PAGE_BYTES),
      .REFILL_QUANTUM (REFILL_QUANTUM)
   ) u_cap (
      .clock     (clock),
      .reset     (reset),
      .pages     (pages_ff),
      .mem_limit (wml_ff),
      .budget    (budget)
   );

   // ---------------- request decode ----------------
   op_type           req_op;
   logic [AMT_W-1:0] req_amt;
   logic [6:0]       req_shard;
   logic [5:0]       req_home;
   logic [8:0]       rq9, home9, tgt9;
   logic             req_neg, req_act, req_acc;
   logic [IDX_W-1:0] acc_idx;
   logic [IDX_W-1:0] home_tab [64];

   assign req_op    = op_type'(req_tuser);
   assign req_amt   = req_tdata[47:0];
   assign req_shard = req_tdata[54:48];
   assign req_home  = req_tdata[60:55];

   // home shard reduced modulo the shard count
   for (genvar h = 0; h < 64; h++) begin : g_home
      assign home_tab[h] = IDX_W'(h % SHARDS);
   end

   assign rq9     = {2'b00, req_shard};
   assign req_neg = req_shard[6];
   assign home9   = 9'(home_tab[req_home]);

   always_comb begin
      tgt9    = rq9;
      req_act = 1'b0;
      case (req_op)
         OP_CHECK: begin
            tgt9    = req_neg ? home9 : rq9;
            req_act = (tgt9 < SHARDS9);
         end
         OP_SOFT: begin
            tgt9    = home9;
            req_act = 1'b1;
         end
         OP_RELEASE: begin
            req_act = (req_amt != '0) && !req_neg && (rq9 < SHARDS9);
         end
         default: begin
            req_act = 1'b0;
         end
      endcase
   end

   assign acc_idx = tgt9[IDX_W-1:0];

   // ---------------- sequencer and datapath ----------------
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [AMT_W-1:0] amt_ff, amt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [6:0]       used_ff, used_in;
   logic             act_ff, act_in;
   logic             vld_ff, vld_in;
   logic [SHARDS-1:0] valid_ff, valid_in;
   logic [CTR_W-1:0] new_ff, new_in;
   logic [TOT_W-1:0] base_ff, base_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [TOT_W-1:0] peak_ff, peak_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_granted_ff, rsp_granted_in;
   logic [6:0]       rsp_used_ff, rsp_used_in;

   logic [CTR_W-1:0] rd_data, old_ctr;
   logic [57:0]      old58, amt58, sum58;
   logic             sum_fits;
   logic [POS_W-1:0] pos_old, pos_new;
   logic [TOT_W-1:0] cand;
   logic             within_limit, commit_wr, commit_go, slot_free;

   assign req_tready = (state_ff == ST_IDLE) && (settle_ff == 2'd0) && !csr_psel;
   assign req_acc    = req_tvalid & req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // execute: saturating counter update
   always_comb begin
      old_ctr  = vld_ff ? rd_data : '0;
      old58    = {{2{old_ctr[CTR_W-1]}}, old_ctr};
      amt58    = 58'(amt_ff);
      sum58    = (op_ff == OP_RELEASE) ? (old58 - amt58) : (old58 + amt58);
      sum_fits = (sum58[57:55] == 3'b000) || (sum58[57:55] == 3'b111);
      if (sum_fits) begin
         new_in = sum58[CTR_W-1:0];
      end else begin
         new_in = sum58[57] ? CTR_MIN : CTR_MAX;
      end
      pos_old = old_ctr[CTR_W-1] ? '0 : old_ctr[POS_W-1:0];
      base_in = total_ff - TOT_W'(pos_old);
   end

   // commit: limit check on the new total
   always_comb begin
      pos_new      = new_ff[CTR_W-1] ? '0 : new_ff[POS_W-1:0];
      cand         = base_ff + TOT_W'(pos_new);
      within_limit = (64'(cand) <= 64'(budget.limit));
      commit_wr    = act_ff && ((op_ff != OP_CHECK) || within_limit);
      commit_go    = (state_ff == ST_COMMIT) && slot_free;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      amt_in         = amt_ff;
      idx_in         = idx_ff;
      used_in        = used_ff;
      act_in         = act_ff;
      vld_in         = vld_ff;
      valid_in       = valid_ff;
      total_in       = total_ff;
      peak_in        = peak_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in    = req_op;
               amt_in   = req_amt;
               idx_in   = acc_idx;
               used_in  = tgt9[6:0];
               act_in   = req_act;
               vld_in   = valid_ff[acc_idx];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               if (commit_wr) begin
                  valid_in[idx_ff] = 1'b1;
                  total_in         = cand;
                  if ((op_ff != OP_RELEASE) && (cand > peak_ff)) begin
                     peak_in = cand;
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_granted_in = (op_ff == OP_STATUS) || commit_wr;
               rsp_used_in    = commit_wr ? used_ff : SHARD_NONE;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      amt_ff         <= amt_in;
      idx_ff         <= idx_in;
      used_ff        <= used_in;
      act_ff         <= act_in;
      vld_ff         <= vld_in;
      // RAM read data follows the request port, so capture the update once
      if (state_ff == ST_EXEC) begin
         new_ff  <= new_in;
         base_ff <= base_in;
      end
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

   // shard counters; read issued at accept, written back at commit
   smba_ram #(
      .WIDTH (CTR_W),
      .DEPTH (SHARDS)
   ) u_ctr_ram (
      .clock   (clock),
      .wr_en   (commit_go && commit_wr),
      .wr_addr (idx_ff),
      .wr_data (new_ff),
      .rd_addr (acc_idx),
      .rd_data (rd_data)
   );

   // ---------------- response ----------------
   // total and peak stay stable while a response waits; cap too, unless a csr write comes
   logic [63:0]      total64, peak64, head64;
   logic [CAP_W-1:0] headroom;

   always_comb begin
      total64  = 64'(total_ff);
      peak64   = 64'(peak_ff);
      head64   = 64'(budget.cap) - total64;
      headroom = (total64 < 64'(budget.cap)) ? head64[CAP_W-1:0] : '0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, peak64[61:0], budget.cap, headroom, total64[61:0],
                        rsp_used_ff, rsp_granted_ff};

   // ---------------- assertions ----------------
   a_peak_covers_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= peak_ff)
      else $error("reserved total exceeds recorded peak");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_COMMIT))
      else $error("response raised outside commit step");

   a_cap_in_range: assert property (@(posedge clock) disable iff (reset)
      (64'(budget.cap) >= MIN_CAP) && (64'(budget.cap) <= MAX_CAP))
      else $error("cap out of range");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

endmodule

`default_nettype wire

/* hdl/smba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smba_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/smba_cap.sv */
// Budget cap pipeline: derives cap and reserve limit from the configuration.
`default_nettype none

module smba_cap
   import smba_pkg::*;
#(
   parameter int SHARDS         = 64,
   parameter int PAGE_BYTES     = 16384,
   parameter int REFILL_QUANTUM = 262144
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [30:0] pages,
   input  wire logic [47:0] mem_limit,
   output budget_type       budget
);

   localparam int          BUF_W = 31 + $clog2(PAGE_BYTES + 1);
   localparam logic [63:0] SLACK = 64'(SHARDS) * 64'(REFILL_QUANTUM);

   logic [BUF_W-1:0] pbuf_ff, pbuf_in;
   logic [BUF_W-1:0] dsel_ff, dsel_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [LIM_W-1:0] limit_ff, limit_in;

   logic [63:0] lo, hi, wm64, dmax, d64;

   // stage 1: buffer bytes
   assign pbuf_in = BUF_W'(pages) * BUF_W'(PAGE_BYTES);

   // stage 2: pick work memory between buffer/8 and buffer/2; an empty buffer pins both to 64 MiB
   always_comb begin
      wm64 = 64'(mem_limit);
      lo   = (pbuf_ff == '0) ? MIN_CAP : 64'(pbuf_ff >> 3);
      hi   = (pbuf_ff == '0) ? MIN_CAP : 64'(pbuf_ff >> 1);
      dmax = (wm64 > lo) ? wm64 : lo;
      dsel_in = BUF_W'((dmax > hi) ? hi : dmax);
   end

   // stage 3: absolute clamp
   always_comb begin
      d64 = 64'(dsel_ff);
      if (d64 < MIN_CAP) begin
         cap_in = CAP_W'(MIN_CAP);
      end else if (d64 > MAX_CAP) begin
         cap_in = CAP_W'(MAX_CAP);
      end else begin
         cap_in = CAP_W'(d64);
      end
   end

   // stage 4: add refill slack
   assign limit_in = LIM_W'(64'(cap_ff) + SLACK);

   always_ff @(posedge clock) begin
      if (reset) begin
         pbuf_ff  <= '0;
         dsel_ff  <= BUF_W'(MIN_CAP);
         cap_ff   <= CAP_W'(MIN_CAP);
         limit_ff <= LIM_W'(MIN_CAP + SLACK);
      end else begin
         pbuf_ff  <= pbuf_in;
         dsel_ff  <= dsel_in;
         cap_ff   <= cap_in;
         limit_ff <= limit_in;
      end
   end

   assign budget.cap   = cap_ff;
   assign budget.limit = limit_ff;

endmodule

`default_nettype wire

/* tb/tb_sharded_memory_budget_accountant.sv */
// Self-checking testbench for the sharded memory budget accountant.
module tb_sharded_memory_budget_accountant;
   import smba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SHARDS      = 64;
   localparam int PAGE_SIZE       = 16384;
   localparam int REFILL_BYTES    = 262144;
   localparam int HOLD_OFF_CYCLES = 90;
   localparam int WATCHDOG_LIMIT  = 2000;

   // register map: registers sit 8 bytes apart, one per 64-bit word; the work memory register is 48 bits wide
   localparam logic [3:0] REG_PAGES = 4'h0;
   localparam logic [3:0] REG_LIMIT = 4'h8;

   // shard counters are 56-bit signed and saturate at these bounds
   localparam longint LEVEL_MAX = 64'sd36028797018963967;
   localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
   localparam logic [47:0] AMOUNT_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        granted;
      logic [6:0]  shard;
      logic [61:0] total;
      logic [32:0] headroom;
      logic [32:0] cap;
      logic [61:0] peak;
   } budget_report;

   typedef struct {
      op_type       op;
      logic [47:0]  amount;
      logic [6:0]   shard_req;
      logic [5:0]   home;
      bit           typed;
      budget_report rpt;
   } script_row;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;    // amount[47:0], shard_req[54:48], home_shard[60:55]
   logic [1:0]    req_tuser;    // op[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [199:0]  rsp_tdata;    // granted[0], shard_used[7:1], total[69:8], headroom[102:70],
                                // cap_now[135:103], peak[197:136]
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [63:0]   csr_pwdata;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   // mirror of the block's state
   logic signed [55:0] shard_level [NUM_SHARDS];
   logic [63:0]        reserved_sum;
   logic [63:0]        peak_sum;
   logic [30:0]        budget_pages;
   logic [47:0]        budget_limit;

   budget_report budget_reports [$];   // reports still owed by the block, oldest first
   script_row    opening_script [$];

   int  mismatches;
   int  requests_sent;
   int  reports_seen;
   int  refusals;
   int  clamp_hits;
   int  settings_applied;
   int  burst_left;
   int  idle_cycles;
   bit  hold_off_pending;

   sharded_memory_budget_accountant #(
      .SHARDS         (NUM_SHARDS),
      .PAGE_BYTES     (PAGE_SIZE),
      .REFILL_QUANTUM (REFILL_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- budget model

   // cap = clamp(min(max(limit, buffer/8), buffer/2), 64MiB, 4GiB);
   // an empty buffer pins both bounds to 64MiB
   function automatic logic [63:0] budget_cap();
      logic [63:0] buf_bytes, lo, hi, d;
      buf_bytes = {33'd0, budget_pages} * 64'(PAGE_SIZE);
      lo = (buf_bytes != 0) ? buf_bytes / 8 : MIN_CAP;
      hi = (buf_bytes != 0) ? buf_bytes / 2 : MIN_CAP;
      d = ({16'd0, budget_limit} > lo) ? {16'd0, budget_limit} : lo;
      if (d > hi) d = hi;
      if (d < MIN_CAP) d = MIN_CAP;
      if (d > MAX_CAP) d = MAX_CAP;
      return d;
   endfunction

   function automatic logic [63:0] positive_part(logic signed [55:0] v);
      return (v > 0) ? 64'(v) : 64'd0;
   endfunction

   function automatic logic signed [55:0] saturate(logic signed [55:0] level, longint delta);
      longint sum;
      sum = level;
      sum = sum + delta;
      if (sum > LEVEL_MAX) begin
         sum = LEVEL_MAX;
         clamp_hits++;
      end else if (sum < LEVEL_MIN) begin
         sum = LEVEL_MIN;
         clamp_hits++;
      end
      return sum[55:0];
   endfunction

   // keeps the sum of positive counters in step with every counter write
   function automatic void set_level(logic [5:0] s, logic signed [55:0] v);
      reserved_sum = reserved_sum - positive_part(shard_level[s]);
      shard_level[s] = v;
      reserved_sum = reserved_sum + positive_part(v);
   endfunction

   function automatic budget_report apply_request(op_type op, logic [47:0] amt,
                                                  logic [6:0] sreq, logic [5:0] home);
      budget_report rpt;
      logic [63:0] cap;
      logic signed [55:0] prior;
      logic [5:0] s;
      cap = budget_cap();
      rpt.granted = 1'b0;
      rpt.shard = SHARD_NONE;
      case (op)
         OP_CHECK: begin
            // negative request falls back to the home shard; a non-negative 7-bit
            // request never exceeds 63, so the out-of-range refusal cannot occur
            s = sreq[6] ? home : sreq[5:0];
            prior = shard_level[s];
            set_level(s, saturate(prior, longint'({16'd0, amt})));
            if (reserved_sum <= cap + 64'(NUM_SHARDS) * 64'(REFILL_BYTES)) begin
               if (reserved_sum > peak_sum) peak_sum = reserved_sum;
               rpt.granted = 1'b1;
               rpt.shard = {1'b0, s};
            end else begin
               set_level(s, prior);   // over budget: charge rolled back exactly
               refusals++;
            end
         end
         OP_SOFT: begin
            set_level(home, saturate(shard_level[home], longint'({16'd0, amt})));
            if (reserved_sum > peak_sum) peak_sum = reserved_sum;
            rpt.granted = 1'b1;
            rpt.shard = {1'b0, home};
         end
         OP_RELEASE: begin
            // zero bytes or a negative shard: ignored
            if (amt != 0 && !sreq[6]) begin
               s = sreq[5:0];
               set_level(s, saturate(shard_level[s], -longint'({16'd0, amt})));
               rpt.granted = 1'b1;
               rpt.shard = sreq;
            end
         end
         default: rpt.granted = 1'b1;
      endcase
      rpt.total = reserved_sum[61:0];
      rpt.headroom = (reserved_sum < cap) ? 33'(cap - reserved_sum) : 33'd0;
      rpt.cap = cap[32:0];
      rpt.peak = peak_sum[61:0];
      return rpt;
   endfunction

   function automatic budget_report make_report(logic g, logic [6:0] s, logic [61:0] total,
                                                logic [32:0] head, logic [32:0] cap,
                                                logic [61:0] peak);
      budget_report rpt;
      rpt.granted = g;
      rpt.shard = s;
      rpt.total = total;
      rpt.headroom = head;
      rpt.cap = cap;
      rpt.peak = peak;
      return rpt;
   endfunction

   function automatic void add_row(op_type op, logic [47:0] amt, logic [6:0] sreq,
                                   logic [5:0] home, bit typed, budget_report rpt);
      script_row row;
      row.op = op;
      row.amount = amt;
      row.shard_req = sreq;
      row.home = home;
      row.typed = typed;
      row.rpt = rpt;
      opening_script.push_back(row);
   endfunction

   // ---------------------------------------------------------------- drivers

   // One request transfer. Data changes at the falling edge; the transfer is taken at the
   // rising edge where ready is seen high. Valid stays up across a burst and only drops
   // for a gap, so it never gets two assignments in one step.
   task automatic send_request(op_type op, logic [47:0] amt, logic [6:0] sreq,
                               logic [5:0] home, bit typed, budget_report typed_rpt);
      budget_report rpt;
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'd0, home, sreq, amt};
      do @(posedge clock); while (!req_tready);
      rpt = apply_request(op, amt, sreq, home);
      budget_reports.push_back(typed ? typed_rpt : rpt);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 6);
      end
   endtask

   // Drop valid and let the block run dry; spare cycles at the end cover its pipeline.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (budget_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB transfer: setup cycle, then access cycle completing when pready is high.
   task automatic csr_access(bit wr, logic [3:0] addr, logic [63:0] wdata,
                             output logic [63:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // New budget setting, only with the block idle. Upper bits of wdata beyond the
   // register width are dropped by the block, so the mirror masks them the same way.
   task automatic set_budget(logic [63:0] pages_word, logic [63:0] limit_word);
      logic [63:0] rd;
      wait_drained();
      csr_access(1'b1, REG_PAGES, pages_word, rd);
      csr_access(1'b1, REG_LIMIT, limit_word, rd);
      budget_pages = pages_word[30:0];
      budget_limit = limit_word[47:0];
      settings_applied++;
      csr_access(1'b0, REG_PAGES, 64'd0, rd);
      if (rd !== {33'd0, budget_pages}) begin
         $display("%0t: page buffer register read back: expected %0h, got %0h",
                  $time, budget_pages, rd);
         mismatches++;
      end
      csr_access(1'b0, REG_LIMIT, 64'd0, rd);
      if (rd !== {16'd0, budget_limit}) begin
         $display("%0t: work memory register read back: expected %0h, got %0h",
                  $time, budget_limit, rd);
         mismatches++;
      end
   endtask

   // Random request scaled to the current cap, so grants and refusals both stay common.
   // Shards lean on 0..7 so counters build up and go negative.
   task automatic draw_request(output op_type op, output logic [47:0] amt,
                               output logic [6:0] sreq, output logic [5:0] home);
      logic [63:0] cap;
      int k;
      cap = budget_cap();
      k = $urandom_range(0, 99);
      if (k < 40) op = OP_CHECK;
      else if (k < 55) op = OP_SOFT;
      else if (k < 90) op = OP_RELEASE;
      else op = OP_STATUS;
      k = $urandom_range(0, 99);
      if (k < 4) amt = 48'd0;
      else if (k < 10 && op != OP_SOFT) amt = 48'({$urandom(), $urandom()});
      else if (op == OP_SOFT) amt = 48'($urandom_range(0, 32'(cap / 8)));
      else if (op == OP_RELEASE) amt = 48'($urandom_range(0, 32'(cap / 2)));
      else amt = 48'($urandom_range(0, 32'(cap / 4)));
      k = $urandom_range(0, 99);
      if (k < 70) sreq = 7'($urandom_range(0, 7));
      else if (k < 85) sreq = 7'(64 + $urandom_range(0, 63));   // -64 .. -1
      else sreq = 7'($urandom_range(0, 63));
      home = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
   endtask

   // ---------------------------------------------------------------- receiver

   // Ready follows a randomly redrawn stall pattern; a pending hold-off request overrides it
   // with one long closed stretch so the block backs up into its request side.
   initial begin
      int cycle;
      int stall_pct;
      rsp_tready = 1'b0;
      cycle = 0;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            if (cycle % 48 == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
         cycle++;
      end
   end

   // ---------------------------------------------------------------- response check

   always @(posedge clock) begin : check_reports
      budget_report got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.granted = rsp_tdata[0];
         got.shard = rsp_tdata[7:1];
         got.total = rsp_tdata[69:8];
         got.headroom = rsp_tdata[102:70];
         got.cap = rsp_tdata[135:103];
         got.peak = rsp_tdata[197:136];
         reports_seen++;
         if (budget_reports.size() == 0) begin
            $display("%0t: response transfer with nothing outstanding: got %p", $time, got);
            mismatches++;
         end else begin
            want = budget_reports.pop_front();
            if (got !== want) begin
               $display("%0t: response mismatch", $time);
               $display("  expected granted %0d shard %0d total %0d headroom %0d cap %0d peak %0d",
                        want.granted, $signed(want.shard), want.total, want.headroom,
                        want.cap, want.peak);
               $display("  actual   granted %0d shard %0d total %0d headroom %0d cap %0d peak %0d",
                        got.granted, $signed(got.shard), got.total, got.headroom,
                        got.cap, got.peak);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any transfer on any port resets the count of dead cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
                  $time, idle_cycles, budget_reports.size());
         $display("tb_sharded_memory_budget_accountant failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      op_type      op;
      logic [47:0] amt;
      logic [6:0]  sreq;
      logic [5:0]  home;
      int          item_count;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_STATUS;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_off_pending = 1'b0;
      idle_cycles = 0;
      burst_left = 0;
      foreach (shard_level[i]) shard_level[i] = '0;
      reserved_sum = '0;
      peak_sum = '0;
      budget_pages = '0;
      budget_limit = '0;
      settings_applied = 1;   // reset setting: 64 MiB cap

      // Opening script, run at the reset setting (cap 64 MiB, slack 16 MiB, limit 80 MiB).
      // Rows whose report is plain from the numbers carry it; the rest go through the model.
      add_row(OP_STATUS, 48'd0, SHARD_NONE, 6'd0, 1'b1,
              make_report(1'b1, SHARD_NONE, 62'd0, 33'd67108864, 33'd67108864, 62'd0));
      // exactly at cap plus slack: granted
      add_row(OP_CHECK, 48'd83886080, 7'd3, 6'd0, 1'b1,
              make_report(1'b1, 7'd3, 62'd83886080, 33'd0, 33'd67108864, 62'd83886080));
      // one byte over: refused and rolled back
      add_row(OP_CHECK, 48'd1, 7'd3, 6'd0, 1'b1,
              make_report(1'b0, SHARD_NONE, 62'd83886080, 33'd0, 33'd67108864, 62'd83886080));
      // zero release ignored
      add_row(OP_RELEASE, 48'd0, 7'd3, 6'd0, 1'b1,
              make_report(1'b0, SHARD_NONE, 62'd83886080, 33'd0, 33'd67108864, 62'd83886080));
      // release to shard -1 ignored
      add_row(OP_RELEASE, 48'd5, SHARD_NONE, 6'd0, 1'b1,
              make_report(1'b0, SHARD_NONE, 62'd83886080, 33'd0, 33'd67108864, 62'd83886080));
      add_row(OP_RELEASE, 48'd83886080, 7'd3, 6'd0, 1'b1,
              make_report(1'b1, 7'd3, 62'd0, 33'd67108864, 33'd67108864, 62'd83886080));
      // soft reserve ignores shard_req and the budget
      add_row(OP_SOFT, AMOUNT_MAX, 7'd0, 6'd63, 1'b0, '0);
      add_row(OP_CHECK, 48'd1000, 7'd5, 6'd0, 1'b0, '0);
      add_row(OP_RELEASE, AMOUNT_MAX, 7'd63, 6'd0, 1'b0, '0);
      // most negative request still picks the home shard
      add_row(OP_CHECK, 48'd1000, 7'h40, 6'd5, 1'b0, '0);
      add_row(OP_CHECK, 48'd0, 7'd63, 6'd0, 1'b0, '0);
      // drive a shard deep negative, then charge it back for free
      add_row(OP_RELEASE, AMOUNT_MAX, 7'd10, 6'd0, 1'b0, '0);
      add_row(OP_CHECK, AMOUNT_MAX, 7'd10, 6'd0, 1'b0, '0);
      add_row(OP_SOFT, 48'd0, 7'd0, 6'd0, 1'b0, '0);
      add_row(OP_CHECK, 48'hAAAA_AAAA_AAAA, 7'h55, 6'h2A, 1'b0, '0);
      add_row(OP_CHECK, 48'h5555_5555_5555, 7'h2A, 6'h15, 1'b0, '0);
      add_row(OP_RELEASE, 48'h5555_5555_5555, 7'h2A, 6'h15, 1'b0, '0);
      add_row(OP_SOFT, 48'h5555_5555_5555, 7'h55, 6'h2A, 1'b0, '0);
      add_row(OP_STATUS, AMOUNT_MAX, 7'h2A, 6'h15, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_script[i])
         send_request(opening_script[i].op, opening_script[i].amount,
                      opening_script[i].shard_req, opening_script[i].home,
                      opening_script[i].typed, opening_script[i].rpt);

      // Random phases, each at its own budget setting. Every phase boundary drains the
      // block completely before the registers change.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_budget(64'd65536, 64'd300000000);                 // 1 GiB buffer, cap 300M
            1: set_budget(64'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF);        // both at maximum: 4 GiB
            2: set_budget(64'd8192, 64'd0);                          // small buffer, floor cap
            3: set_budget({$urandom(), $urandom()}, {$urandom(), $urandom()});
            default: set_budget(64'd0, 64'd0);                       // back to reset values
         endcase
         // first phase: receiver shuts for a long stretch while requests keep coming
         if (phase == 0) hold_off_pending = 1'b1;
         item_count = (phase < 4) ? 200 : 450;
         for (int n = 0; n < item_count; n++) begin
            draw_request(op, amt, sreq, home);
            // last phase pushes shard 0 into both saturation limits: max soft charges up
            // past +2^55, then max releases down past -2^55, with some noise mixed in
            if (phase == 4 && $urandom_range(0, 9) != 0) begin
               amt = AMOUNT_MAX;
               home = 6'd0;
               if (n < 150) begin
                  op = OP_SOFT;
               end else begin
                  op = OP_RELEASE;
                  sreq = 7'd0;
               end
            end
            send_request(op, amt, sreq, home, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d requests over %0d budget settings: %0d responses,",
               requests_sent, settings_applied, reports_seen);
      $display("%0d refused checked reserves, %0d counter saturations, peak total %0d bytes.",
               refusals, clamp_hits, peak_sum);
      if (mismatches == 0 && budget_reports.size() == 0) begin
         $display("tb_sharded_memory_budget_accountant passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, budget_reports.size());
         $display("tb_sharded_memory_budget_accountant failed");
      end
      $finish;
   end

endmodule
